// ===== rtl/core/ailt_pkg.sv =====
// ailt_pkg: shared types, codes and sizes for the aging id table.
// No dependencies; used by every module of the block.
package ailt_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(MAX_RESULTS);
  localparam int ID_W         = 32;
  localparam int TIME_W       = 32;
  localparam int REQ_W        = 3;
  localparam int DATA_W       = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_LSB  = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DATA_W-1:0] MAX_AGE_RESET = 32'd1000;
  localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_MAX_AGE = '0;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SWEEP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_SWEEP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   obj_id;
    logic [TIME_W-1:0] now_time;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_SWEEP_CHK,
    ST_MIN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/ailt_front.sv =====
// ailt_front: accepts requests, decodes the request type into an opcode and
// buffers decoded commands in a short queue. Depends on ailt_pkg.
module ailt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ailt_pkg::REQ_W-1:0]   in_req_type,
  input  logic [ailt_pkg::ID_W-1:0]    in_obj_id,
  input  logic [ailt_pkg::TIME_W-1:0]  in_now_time,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output ailt_pkg::cmd_t               cmd
);

  ailt_pkg::cmd_t                  q_r [ailt_pkg::QUEUE_DEPTH];
  logic [ailt_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ailt_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ailt_pkg::QCNT_W-1:0]     count_r, count_nxt;
  ailt_pkg::cmd_t                  dec;
  logic                            push, pop;

  always_comb begin
    dec.obj_id   = in_obj_id;
    dec.now_time = in_now_time;
    unique case (in_req_type)
      ailt_pkg::REQ_ADD:    dec.op = ailt_pkg::OP_ADD;
      ailt_pkg::REQ_REMOVE: dec.op = ailt_pkg::OP_REMOVE;
      ailt_pkg::REQ_QUERY:  dec.op = ailt_pkg::OP_QUERY;
      ailt_pkg::REQ_SWEEP:  dec.op = ailt_pkg::OP_SWEEP;
      ailt_pkg::REQ_CLEAR:  dec.op = ailt_pkg::OP_CLEAR;
      default:              dec.op = ailt_pkg::OP_NOP;
    endcase
  end

  assign in_ready  = (count_r != ailt_pkg::QCNT_W'(ailt_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ailt_pkg::QPTR_W'(ailt_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ailt_pkg::QPTR_W'(ailt_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/core/ailt_back.sv =====
// ailt_back: executes queued commands against the entry table, scanning one
// entry per cycle, and drives the registered result channel. Depends on ailt_pkg.
module ailt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  ailt_pkg::cmd_t                cmd,
  input  logic [ailt_pkg::DATA_W-1:0]   max_age,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic                          out_table_full,
  output logic                          out_expired_valid,
  output logic [ailt_pkg::ID_W-1:0]     out_expired_id,
  output logic                          out_table_empty,
  output logic                          out_last
);

  ailt_pkg::state_t                   state_r, state_nxt;
  ailt_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic [ailt_pkg::TABLE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [ailt_pkg::TABLE_DEPTH-1:0]   hit_r, hit_nxt;
  logic [ailt_pkg::ID_W-1:0]          ent_id_r    [ailt_pkg::TABLE_DEPTH];
  logic [ailt_pkg::TIME_W-1:0]        ent_stamp_r [ailt_pkg::TABLE_DEPTH];
  logic [ailt_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic                               match_hit_r, match_hit_nxt;
  logic [ailt_pkg::IDX_W-1:0]         match_idx_r, match_idx_nxt;
  logic                               free_hit_r, free_hit_nxt;
  logic [ailt_pkg::IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic                               best_hit_r, best_hit_nxt;
  logic [ailt_pkg::IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [ailt_pkg::ID_W-1:0]          best_id_r, best_id_nxt;
  logic [ailt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               empty_r, empty_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_full_r, out_xv_r, out_empty_r;
  logic                               out_last_r;
  logic [ailt_pkg::ID_W-1:0]          out_xid_r;

  logic                               emit;
  logic                               o_found, o_full, o_xv, o_last;
  logic [ailt_pkg::ID_W-1:0]          o_xid;
  logic                               we_id, we_stamp;
  logic [ailt_pkg::IDX_W-1:0]         we_idx;

  logic [ailt_pkg::ID_W-1:0]          cur_id;
  logic [ailt_pkg::TIME_W-1:0]        cur_stamp;
  logic [ailt_pkg::TIME_W-1:0]        age;
  logic                               cur_valid, scan_last, expire, out_free;

  assign cur_id    = ent_id_r[idx_r];
  assign cur_stamp = ent_stamp_r[idx_r];
  assign cur_valid = valid_r[idx_r];
  assign scan_last = (idx_r == ailt_pkg::IDX_W'(ailt_pkg::TABLE_DEPTH - 1));
  assign age       = cmd_r.now_time - cur_stamp;
  assign expire    = cur_valid && (cmd_r.now_time > cur_stamp) && (age >= max_age);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r;
    hit_nxt       = hit_r;
    idx_nxt       = scan_last ? '0 : idx_r + 1'b1;
    match_hit_nxt = match_hit_r;
    match_idx_nxt = match_idx_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    best_hit_nxt  = best_hit_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    cnt_nxt       = cnt_r;
    empty_nxt     = empty_r;
    cmd_ready     = 1'b0;
    emit          = 1'b0;
    o_found       = 1'b0;
    o_full        = 1'b0;
    o_xv          = 1'b0;
    o_xid         = '0;
    o_last        = 1'b1;
    we_id         = 1'b0;
    we_stamp      = 1'b0;
    we_idx        = match_idx_r;

    unique case (state_r)
      ailt_pkg::ST_IDLE: begin
        cmd_ready     = 1'b1;
        idx_nxt       = '0;
        match_hit_nxt = 1'b0;
        free_hit_nxt  = 1'b0;
        hit_nxt       = '0;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          unique case (cmd.op)
            ailt_pkg::OP_ADD,
            ailt_pkg::OP_REMOVE,
            ailt_pkg::OP_QUERY:  state_nxt = ailt_pkg::ST_SCAN;
            ailt_pkg::OP_SWEEP:  state_nxt = ailt_pkg::ST_HIT;
            default:             state_nxt = ailt_pkg::ST_EMIT;
          endcase
        end
      end

      ailt_pkg::ST_SCAN: begin
        if (cur_valid && (cur_id == cmd_r.obj_id) && !match_hit_r) begin
          match_hit_nxt = 1'b1;
          match_idx_nxt = idx_r;
        end
        if (!cur_valid && !free_hit_r) begin
          free_hit_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (scan_last) begin
          state_nxt = ailt_pkg::ST_EMIT;
        end
      end

      ailt_pkg::ST_HIT: begin
        hit_nxt[idx_r] = expire;
        if (scan_last) begin
          state_nxt = ailt_pkg::ST_SWEEP_CHK;
        end
      end

      ailt_pkg::ST_SWEEP_CHK: begin
        // empty after the sweep only if every valid entry expires and all fit
        empty_nxt    = ~|(valid_r & ~hit_r) &&
                       ($countones(hit_r) <= ailt_pkg::MAX_RESULTS);
        best_hit_nxt = 1'b0;
        cnt_nxt      = '0;
        idx_nxt      = '0;
        state_nxt    = (|hit_r) ? ailt_pkg::ST_MIN : ailt_pkg::ST_EMIT;
      end

      ailt_pkg::ST_MIN: begin
        if (hit_r[idx_r] && (!best_hit_r || (cur_id < best_id_r))) begin
          best_hit_nxt = 1'b1;
          best_idx_nxt = idx_r;
          best_id_nxt  = cur_id;
        end
        if (scan_last) begin
          state_nxt = ailt_pkg::ST_EMIT;
        end
      end

      ailt_pkg::ST_EMIT: begin
        idx_nxt = '0;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ailt_pkg::ST_IDLE;
          unique case (cmd_r.op)
            ailt_pkg::OP_ADD: begin
              if (match_hit_r) begin
                we_stamp = 1'b1;
                we_idx   = match_idx_r;
              end else if (free_hit_r) begin
                we_id             = 1'b1;
                we_stamp          = 1'b1;
                we_idx            = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                o_full = 1'b1;
              end
            end
            ailt_pkg::OP_REMOVE: begin
              o_found = match_hit_r;
              if (match_hit_r) begin
                valid_nxt[match_idx_r] = 1'b0;
              end
            end
            ailt_pkg::OP_QUERY: begin
              o_found = match_hit_r;
            end
            ailt_pkg::OP_SWEEP: begin
              if (best_hit_r) begin
                valid_nxt[best_idx_r] = 1'b0;
                hit_nxt[best_idx_r]   = 1'b0;
                o_xv    = 1'b1;
                o_xid   = best_id_r;
                cnt_nxt = cnt_r + 1'b1;
                if ((|hit_nxt) &&
                    (cnt_r != ailt_pkg::CNT_W'(ailt_pkg::MAX_RESULTS - 1))) begin
                  o_last       = 1'b0;
                  best_hit_nxt = 1'b0;
                  state_nxt    = ailt_pkg::ST_MIN;
                end
              end
            end
            ailt_pkg::OP_CLEAR: begin
              valid_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ailt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ailt_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hit_r       <= hit_nxt;
    idx_r       <= idx_nxt;
    match_hit_r <= match_hit_nxt;
    match_idx_r <= match_idx_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    best_hit_r  <= best_hit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    cnt_r       <= cnt_nxt;
    empty_r     <= empty_nxt;
    if (we_id) begin
      ent_id_r[we_idx] <= cmd_r.obj_id;
    end
    if (we_stamp) begin
      ent_stamp_r[we_idx] <= cmd_r.now_time;
    end
    if (emit) begin
      out_found_r <= o_found;
      out_full_r  <= o_full;
      out_xv_r    <= o_xv;
      out_xid_r   <= o_xid;
      out_last_r  <= o_last;
      out_empty_r <= (cmd_r.op == ailt_pkg::OP_SWEEP) ? empty_r : ~|valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_table_full    = out_full_r;
  assign out_expired_valid = out_xv_r;
  assign out_expired_id    = out_xid_r;
  assign out_table_empty   = out_empty_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/core/aging_id_lock_table_top.sv =====
// Aging id table top: add, remove and query scan every entry, then give one result;
// a sweep marks expired entries in one scan, then emits one result per expired id,
// smallest first, one scan each (one if none); clear and undefined requests go
// straight to the result. One request at a time, paced by the single entry compare
// walking the table one entry per cycle. Reset (rst_n low, synchronous): entries
// invalid, max_age = 1000, queue and result register empty. Uses ailt_front/back.
module aging_id_lock_table_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ailt_pkg::REQ_W-1:0]           in_req_type,
  input  logic [ailt_pkg::ID_W-1:0]            in_obj_id,
  input  logic [ailt_pkg::TIME_W-1:0]          in_now_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic                                 out_table_full,
  output logic                                 out_expired_valid,
  output logic [ailt_pkg::ID_W-1:0]            out_expired_id,
  output logic                                 out_table_empty,
  output logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ailt_pkg::PADDR_W-1:0]         paddr,
  input  logic [ailt_pkg::DATA_W-1:0]          pwdata,
  output logic [ailt_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic [ailt_pkg::DATA_W-1:0] max_age_r, max_age_nxt;
  logic                        sel_max_age, cfg_wr;
  logic                        cmd_valid, cmd_ready;
  ailt_pkg::cmd_t              cmd;

  assign pready      = 1'b1;
  assign sel_max_age = (paddr[ailt_pkg::PADDR_W-1:ailt_pkg::REG_IDX_LSB] ==
                        ailt_pkg::REG_MAX_AGE);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign max_age_nxt = (cfg_wr && sel_max_age) ? pwdata : max_age_r;
  assign prdata      = sel_max_age ? max_age_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= ailt_pkg::MAX_AGE_RESET;
    end else begin
      max_age_r <= max_age_nxt;
    end
  end

  ailt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_obj_id   (in_obj_id),
    .in_now_time (in_now_time),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  ailt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .max_age           (max_age_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_table_full    (out_table_full),
    .out_expired_valid (out_expired_valid),
    .out_expired_id    (out_expired_id),
    .out_table_empty   (out_table_empty),
    .out_last          (out_last)
  );

endmodule

// ===== tb/aging_id_lock_table_top_tb.sv =====
// Self-checking testbench for aging_id_lock_table_top: directed and random table requests.
// A scoreboard class predicts each result; the request, result and APB sides are driven here.
// Depends on ailt_pkg and the aging_id_lock_table_top RTL.
module aging_id_lock_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_NS = 5_000_000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE = 20;
  localparam int REPORT_LIMIT = 10;
  localparam logic [ailt_pkg::REQ_W-1:0] REQ_BAD_LO = 3'd5;
  localparam logic [ailt_pkg::REQ_W-1:0] REQ_BAD_HI = 3'd7;
  localparam logic [ailt_pkg::PADDR_W-1:0] MAX_AGE_ADDR =
    {ailt_pkg::REG_MAX_AGE, {ailt_pkg::REG_IDX_LSB{1'b0}}};

  typedef struct packed {
    logic                      found;
    logic                      full;
    logic                      exp_valid;
    logic [ailt_pkg::ID_W-1:0] exp_id;
    logic                      empty;
    logic                      last;
  } result_t;

  class lock_table_scoreboard;
    logic [ailt_pkg::DATA_W-1:0] max_age;
    bit                          slot_valid[ailt_pkg::TABLE_DEPTH];
    logic [ailt_pkg::ID_W-1:0]   slot_id[ailt_pkg::TABLE_DEPTH];
    logic [ailt_pkg::TIME_W-1:0] slot_stamp[ailt_pkg::TABLE_DEPTH];
    result_t                     expected_q[$];
    int errors, n_requests, n_results, n_expired, n_full, n_found;

    function new();
      max_age = ailt_pkg::MAX_AGE_RESET;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      errors = 0;
      n_requests = 0;
      n_results = 0;
      n_expired = 0;
      n_full = 0;
      n_found = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [ailt_pkg::REQ_W-1:0] req,
                               logic [ailt_pkg::ID_W-1:0] id,
                               logic [ailt_pkg::TIME_W-1:0] now);
      result_t res[ailt_pkg::MAX_RESULTS];
      result_t r;
      bit      hit[ailt_pkg::TABLE_DEPTH];
      bit      empty;
      int      slot, best, n;
      r = '0;
      slot = -1;
      n = 0;
      n_requests++;
      for (int i = 0; i < ailt_pkg::TABLE_DEPTH; i++)
        if (slot < 0 && slot_valid[i] && slot_id[i] == id) slot = i;
      case (req)
        ailt_pkg::REQ_ADD: begin
          if (slot >= 0) begin
            slot_stamp[slot] = now;
          end else begin
            for (int i = ailt_pkg::TABLE_DEPTH - 1; i >= 0; i--)
              if (!slot_valid[i]) slot = i;
            if (slot >= 0) begin
              slot_valid[slot] = 1'b1;
              slot_id[slot] = id;
              slot_stamp[slot] = now;
            end else begin
              r.full = 1'b1;
              n_full++;
            end
          end
          res[0] = r;
          n = 1;
        end
        ailt_pkg::REQ_REMOVE, ailt_pkg::REQ_QUERY: begin
          if (slot >= 0) begin
            r.found = 1'b1;
            n_found++;
            if (req == ailt_pkg::REQ_REMOVE) slot_valid[slot] = 1'b0;
          end
          res[0] = r;
          n = 1;
        end
        ailt_pkg::REQ_SWEEP: begin
          foreach (hit[i])
            hit[i] = slot_valid[i] && now > slot_stamp[i] &&
                     ailt_pkg::TIME_W'(now - slot_stamp[i]) >= max_age;
          while (n < ailt_pkg::MAX_RESULTS) begin
            best = -1;
            for (int i = 0; i < ailt_pkg::TABLE_DEPTH; i++)
              if (hit[i] && (best < 0 || slot_id[i] < slot_id[best])) best = i;
            if (best < 0) break;
            hit[best] = 1'b0;
            slot_valid[best] = 1'b0;
            r = '0;
            r.exp_valid = 1'b1;
            r.exp_id = slot_id[best];
            res[n] = r;
            n++;
            n_expired++;
          end
          if (n == 0) begin
            res[0] = r;
            n = 1;
          end
        end
        ailt_pkg::REQ_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          res[0] = r;
          n = 1;
        end
        default: begin
          res[0] = r;
          n = 1;
        end
      endcase
      empty = 1'b1;
      foreach (slot_valid[i])
        if (slot_valid[i]) empty = 1'b0;
      for (int k = 0; k < n; k++) begin
        res[k].empty = empty;
        res[k].last = (k == n - 1);
        expected_q.insert(expected_q.size(), res[k]);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected result found=%0b full=%0b xv=%0b xid=%h empty=%0b last=%0b",
                   got.found, got.full, got.exp_valid, got.exp_id, got.empty, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found || got.full !== want.full ||
          got.exp_valid !== want.exp_valid || got.exp_id !== want.exp_id ||
          got.empty !== want.empty || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("ERROR: result %0d mismatch at %0t", n_results, $realtime);
          $display("  expected found=%0b full=%0b xv=%0b xid=%h empty=%0b last=%0b",
                   want.found, want.full, want.exp_valid, want.exp_id, want.empty, want.last);
          $display("  actual   found=%0b full=%0b xv=%0b xid=%h empty=%0b last=%0b",
                   got.found, got.full, got.exp_valid, got.exp_id, got.empty, got.last);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ailt_pkg::REQ_W-1:0]    in_req_type = '0;
  logic [ailt_pkg::ID_W-1:0]     in_obj_id = '0;
  logic [ailt_pkg::TIME_W-1:0]   in_now_time = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_found, out_table_full, out_expired_valid;
  logic                          out_table_empty, out_last;
  logic [ailt_pkg::ID_W-1:0]     out_expired_id;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ailt_pkg::PADDR_W-1:0]  paddr = '0;
  logic [ailt_pkg::DATA_W-1:0]   pwdata = '0;
  logic [ailt_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  lock_table_scoreboard sb = new();

  bit                            idle_en = 1'b1;
  bit                            rx_hold_req = 1'b0;
  logic [ailt_pkg::ID_W-1:0]     id_pool[POOL_SIZE];
  logic [ailt_pkg::TIME_W-1:0]   now_t;
  logic [ailt_pkg::DATA_W-1:0]   rand_age;

  aging_id_lock_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_obj_id(in_obj_id), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_table_full(out_table_full), .out_expired_valid(out_expired_valid),
    .out_expired_id(out_expired_id), .out_table_empty(out_table_empty), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_req_type, in_obj_id, in_now_time);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.found = out_found;
      got.full = out_table_full;
      got.exp_valid = out_expired_valid;
      got.exp_id = out_expired_id;
      got.empty = out_table_empty;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_en && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [ailt_pkg::REQ_W-1:0] req,
                              input logic [ailt_pkg::ID_W-1:0] id,
                              input logic [ailt_pkg::TIME_W-1:0] now);
    if (idle_en && $urandom_range(2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_obj_id   <= id;
    in_now_time <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_max_age(input logic [ailt_pkg::DATA_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_AGE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.max_age = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic refill_pool();
    foreach (id_pool[i]) id_pool[i] = $urandom();
  endtask

  task automatic random_items(input int count, input int step_max);
    logic [ailt_pkg::REQ_W-1:0] req;
    logic [ailt_pkg::ID_W-1:0]  id;
    int                         r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45) req = ailt_pkg::REQ_ADD;
      else if (r < 60) req = ailt_pkg::REQ_REMOVE;
      else if (r < 75) req = ailt_pkg::REQ_QUERY;
      else if (r < 92) req = ailt_pkg::REQ_SWEEP;
      else if (r < 96) req = ailt_pkg::REQ_CLEAR;
      else req = ailt_pkg::REQ_W'($urandom_range(int'(REQ_BAD_LO), int'(REQ_BAD_HI)));
      id = ($urandom_range(9) == 0) ? $urandom() : id_pool[$urandom_range(POOL_SIZE - 1)];
      now_t = now_t + ailt_pkg::TIME_W'($urandom_range(step_max));
      send_request(req, id, now_t);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset max_age
    send_request(ailt_pkg::REQ_QUERY, 32'h0, 32'h0);
    send_request(ailt_pkg::REQ_ADD, 32'h0, 32'h0);
    send_request(ailt_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ailt_pkg::REQ_ADD, 32'h0, 32'd5);
    send_request(ailt_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'h0);
    send_request(ailt_pkg::REQ_REMOVE, 32'h0, 32'h0);
    send_request(ailt_pkg::REQ_REMOVE, 32'h0, 32'h0);
    send_request(ailt_pkg::REQ_SWEEP, 32'h0, 32'hFFFF_FFFF);
    send_request(ailt_pkg::REQ_ADD, 32'h1234_5678, 32'd10);
    send_request(ailt_pkg::REQ_SWEEP, 32'h0, 32'd1009);
    send_request(ailt_pkg::REQ_SWEEP, 32'h0, 32'd1010);
    send_request(ailt_pkg::REQ_ADD, 32'hA5A5_A5A5, 32'h0);
    send_request(ailt_pkg::REQ_CLEAR, 32'h0, 32'h0);
    for (int c = int'(REQ_BAD_LO); c <= int'(REQ_BAD_HI); c++)
      send_request(ailt_pkg::REQ_W'(c), $urandom(), $urandom());
    send_request(ailt_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'h0);
    send_request(ailt_pkg::REQ_ADD, 32'h5A5A_5A5A, 32'h0);
    send_request(REQ_BAD_LO, 32'h0, 32'h0);

    // max_age 0: fill the table, overflow it, then sweep everything out
    write_max_age(32'h0);
    refill_pool();
    send_request(ailt_pkg::REQ_CLEAR, 32'h0, 32'h0);
    now_t = ailt_pkg::TIME_W'($urandom_range(1000));
    for (int k = 0; k <= ailt_pkg::TABLE_DEPTH; k++)
      send_request(ailt_pkg::REQ_ADD, id_pool[k], now_t);
    now_t = now_t + 1;
    send_request(ailt_pkg::REQ_SWEEP, $urandom(), now_t);
    random_items(20, 3);
    wait_drained();
    random_items(20, 3);

    // long output stall while requests keep coming
    write_max_age(32'd50);
    refill_pool();
    now_t = $urandom();
    rx_hold_req = 1'b1;
    random_items(40, 30);

    // all-ones max_age: only a zero stamp swept at the top time expires
    write_max_age(32'hFFFF_FFFF);
    send_request(ailt_pkg::REQ_CLEAR, 32'h0, 32'h0);
    for (int k = 0; k < 4; k++) send_request(ailt_pkg::REQ_ADD, id_pool[k], 32'h0);
    for (int k = 4; k < 7; k++) send_request(ailt_pkg::REQ_ADD, id_pool[k], 32'h1);
    send_request(ailt_pkg::REQ_QUERY, id_pool[4], 32'h0);
    send_request(ailt_pkg::REQ_SWEEP, $urandom(), 32'hFFFF_FFFF);
    send_request(ailt_pkg::REQ_SWEEP, $urandom(), 32'hFFFF_FFFF);
    send_request(ailt_pkg::REQ_REMOVE, id_pool[5], 32'h0);

    // random max_age, no idling on either side
    rand_age = ailt_pkg::DATA_W'($urandom_range(20, 200));
    write_max_age(rand_age);
    refill_pool();
    now_t = $urandom();
    idle_en = 1'b0;
    random_items(30, 15);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d results: %0d ids expired, %0d adds dropped full, %0d hits.",
             sb.n_requests, sb.n_results, sb.n_expired, sb.n_full, sb.n_found);
    $display("max_age runs: 1000, 0, 50, all ones and %0d; one %0d-cycle output stall.",
             rand_age, LONG_HOLD);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ailt_pkg.sv
rtl/core/ailt_front.sv
rtl/core/ailt_back.sv
rtl/core/aging_id_lock_table_top.sv
tb/aging_id_lock_table_top_tb.sv
